// File: hdl/qfsqrt_pkg.sv
package qfsqrt_pkg;

  localparam int FRAC_W     = 5;
  localparam int RAD_IN_W   = 32;
  localparam int ROOT_OUT_W = 31;
  localparam int MaxFrac    = 30;

  localparam logic [FRAC_W-1:0] MAX_FRAC_CODE = FRAC_W'(MaxFrac);

endpackage

// File: hdl/qfsqrt_prep.sv
module qfsqrt_prep import qfsqrt_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int RAD_W      = 62
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [RAD_IN_W-1:0] in_radicand,
  input  logic [FRAC_W-1:0]   frac,
  output logic                out_valid,
  output logic [RAD_W-1:0]    out_rad
);

  logic                  valid_r;
  logic [RAD_W-1:0]      rad_r;
  logic [RAD_W-1:0]      rad_nxt;
  logic [DATA_WIDTH-1:0] x;
  logic [FRAC_W-1:0]     shamt;
  logic                  positive;

  assign x        = in_radicand[DATA_WIDTH-1:0];
  assign positive = !x[DATA_WIDTH-1] && (|x);
  // format code 31 saturates to 30
  assign shamt    = (frac > MAX_FRAC_CODE) ? MAX_FRAC_CODE : frac;

  always_comb begin
    rad_nxt = '0;
    if (positive) begin
      rad_nxt = RAD_W'(x[DATA_WIDTH-2:0]) << shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;

endmodule

// File: hdl/qfsqrt_cell.sv
module qfsqrt_cell #(
  parameter int ROOT_W = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_rad,
  input  logic [ROOT_W+1:0]   in_rem,
  input  logic [ROOT_W-1:0]   in_root,
  output logic                out_valid,
  output logic [2*ROOT_W-1:0] out_rad,
  output logic [ROOT_W+1:0]   out_rem,
  output logic [ROOT_W-1:0]   out_root
);

  localparam int RAD_W = 2 * ROOT_W;

  logic              valid_r;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RAD_W-1:0]  rad_nxt;
  logic [ROOT_W+1:0] rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [ROOT_W+1:0] acc;
  logic [ROOT_W+1:0] trial;

  // bring down the next two radicand bits and try root bit one
  assign acc     = {in_rem[ROOT_W-1:0], in_rad[RAD_W-1 -: 2]};
  assign trial   = {in_root, 2'b01};
  assign rad_nxt = {in_rad[RAD_W-3:0], 2'b00};

  always_comb begin
    if (acc >= trial) begin
      rem_nxt  = acc - trial;
      root_nxt = {in_root[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = acc;
      root_nxt = {in_root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;

endmodule

// File: hdl/q_format_square_root_unit.sv
// Channel    Ports                                   Handshake
// -------    -----                                   ---------
// input      start, busy, in_radicand                taken when start && !busy
// result     out_strobe, out_root                    valid for the one strobe cycle
// config     cfg_we, cfg_wdata                       written when cfg_we is high
//
// One item per clock; busy stays low. The pipeline is one prep register, then
// one cell per root bit.
// Synchronous active-low reset clears the valid chain and sets frac_r to 0.
// The receiver cannot stall; each result shows on out_strobe for one cycle.
module q_format_square_root_unit import qfsqrt_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [RAD_IN_W-1:0]   in_radicand,
  output logic                  out_strobe,
  output logic [ROOT_OUT_W-1:0] out_root,
  input  logic                  cfg_we,
  input  logic [FRAC_W-1:0]     cfg_wdata
);

  localparam int ROOT_W = (DATA_WIDTH + MaxFrac) / 2;
  localparam int RAD_W  = 2 * ROOT_W;

  logic [FRAC_W-1:0] frac_r;

  logic              valid_s [ROOT_W+1];
  logic [RAD_W-1:0]  rad_s   [ROOT_W+1];
  logic [ROOT_W+1:0] rem_s   [ROOT_W+1];
  logic [ROOT_W-1:0] root_s  [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= '0;
    end else if (cfg_we) begin
      frac_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  qfsqrt_prep #(
    .DATA_WIDTH (DATA_WIDTH),
    .RAD_W      (RAD_W)
  ) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start),
    .in_radicand (in_radicand),
    .frac        (frac_r),
    .out_valid   (valid_s[0]),
    .out_rad     (rad_s[0])
  );

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    qfsqrt_cell #(
      .ROOT_W (ROOT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_s[i]),
      .in_rad    (rad_s[i]),
      .in_rem    (rem_s[i]),
      .in_root   (root_s[i]),
      .out_valid (valid_s[i+1]),
      .out_rad   (rad_s[i+1]),
      .out_rem   (rem_s[i+1]),
      .out_root  (root_s[i+1])
    );
  end

  assign out_strobe = valid_s[ROOT_W];
  assign out_root   = ROOT_OUT_W'(root_s[ROOT_W]);

endmodule

// File: hdl/qfsqrt_chk.sv
module qfsqrt_chk import qfsqrt_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [RAD_IN_W-1:0]   in_radicand,
  input logic                  out_strobe,
  input logic [ROOT_OUT_W-1:0] out_root
);

  localparam int LAT = (DATA_WIDTH + MaxFrac) / 2 + 1;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised on a fully pipelined unit");

  a_reset_drains: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  a_strobe_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result strobe without an item at the pipeline latency");

  a_negative_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_radicand[DATA_WIDTH-1], LAT)) |-> (out_root == '0))
    else $error("nonzero root for a negative radicand");

  a_zero_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && ($past(in_radicand[DATA_WIDTH-1:0], LAT) == '0)) |-> (out_root == '0))
    else $error("nonzero root for a zero radicand");

endmodule

bind q_format_square_root_unit qfsqrt_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_qfsqrt_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_radicand (in_radicand),
  .out_strobe  (out_strobe),
  .out_root    (out_root)
);
